### design/fba_pkg.sv
// Package for the frame bitmap allocator: operation and register codes,
// and the result type of the find-first-zero unit.
// No dependencies; imported by fba_ffz and frame_bitmap_allocator_core.
package fba_pkg;

  // Request operation codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_TEST  = 2'd2;

  // Register index of the configuration port (paddr[2])
  localparam logic [0:0] REG_FRAME_COUNT = 1'b0;

  // Widths fixed by the request and result words
  localparam int FRAME_W = 12;
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 13'd4096;

  // Lowest clear bit of one bitmap word
  typedef struct packed {
    logic       found;
    logic [4:0] pos;
  } ffz_res_t;

endpackage

### design/fba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the usage bitmap of the allocator.
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fba_ffz.sv
// Find-first-zero unit: position of the lowest clear bit of a 32-bit word.
// Depends on fba_pkg for the result type.
module fba_ffz import fba_pkg::*; (
  input  logic [31:0] word,
  output ffz_res_t    res
);

  logic [31:0] inv;
  logic [31:0] win;
  logic [31:0] lowmask;
  logic [4:0]  pos;

  // Binary search over halves: five narrow steps.
  always_comb begin
    inv     = ~word;
    pos     = '0;
    win     = '0;
    lowmask = '0;
    for (int k = 4; k >= 0; k--) begin
      win     = inv >> pos;
      lowmask = (32'h1 << (1 << k)) - 32'h1;
      if ((win & lowmask) == 32'h0) begin
        pos = pos + 5'(1 << k);
      end
    end
    res.found = |inv;
    res.pos   = pos;
  end

endmodule

### design/frame_bitmap_allocator_core.sv
// Sequence: an alloc of a held frame, or an unused op, goes from idle straight to ST_RESP;
// free and test pass through ST_FT first; a first-fit alloc passes through ST_SCAN, which
// moves on one bitmap word at a time until a clear bit is found or the search limit is reached.
// One word at a time: a new word is taken only when the previous result is registered, and
// the scan reads one bitmap word per cycle through the RAM read port.
// Reset is synchronous; afterwards a clearing pass zeroes all MAX_FRAMES/32 bitmap words
// (128 by default), one RAM word per cycle, while in_stall stays high.
module frame_bitmap_allocator_core import fba_pkg::*; #(
  parameter int MAX_FRAMES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [FRAME_W-1:0] in_frame,
  input  logic               in_kernel,
  input  logic               in_writable,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FRAME_W-1:0] out_frame_index,
  output logic               out_present,
  output logic               out_writable,
  output logic               out_user_access,
  output logic               out_no_free,
  output logic               out_in_use,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int MAP_WORDS = MAX_FRAMES / 32;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAP_WORDS + 1);

  // Sequencer states
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_FT   = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   lim_r, lim_nxt;
  logic [COUNT_W-1:0] frame_count_r, frame_count_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Captured request word
  logic [1:0]         op_r, op_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               kern_r, kern_nxt;
  logic               wr_r, wr_nxt;

  // Pending result
  logic [FRAME_W-1:0] res_frame_r, res_frame_nxt;
  logic               res_present_r, res_present_nxt;
  logic               res_writable_r, res_writable_nxt;
  logic               res_user_r, res_user_nxt;
  logic               res_no_free_r, res_no_free_nxt;
  logic               res_in_use_r, res_in_use_nxt;

  // Output register
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_present_r, out_present_nxt;
  logic               out_writable_r, out_writable_nxt;
  logic               out_user_r, out_user_nxt;
  logic               out_no_free_r, out_no_free_nxt;
  logic               out_in_use_r, out_in_use_nxt;

  // RAM and search unit
  logic               ram_we;
  logic [WA_W-1:0]    ram_waddr;
  logic [31:0]        ram_wdata;
  logic [WA_W-1:0]    ram_raddr;
  logic [31:0]        ram_rdata;
  ffz_res_t           ffz_res;

  logic [31:0]        in_word_ext;
  logic [31:0]        fc_words;
  logic [31:0]        lim_ext;
  logic [31:0]        found_ext;
  logic               frame_in_range;
  logic               cfg_wr;

  fba_ram #(
    .WIDTH (32),
    .DEPTH (MAP_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fba_ffz u_ffz (
    .word (ram_rdata),
    .res  (ffz_res)
  );

  // Address helpers and the search limit in whole words.
  assign in_word_ext    = 32'(in_frame) >> 5;
  assign frame_in_range = 32'(frame_r) < 32'(MAX_FRAMES);
  assign fc_words       = 32'(frame_count_r[COUNT_W-1:5]);
  assign lim_ext        = (fc_words > 32'(MAP_WORDS)) ? 32'(MAP_WORDS) : fc_words;
  assign found_ext      = 32'({scan_idx_r, ffz_res.pos});

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_FRAME_COUNT) ? 32'(frame_count_r) : 32'h0;

  always_comb begin
    frame_count_nxt = frame_count_r;
    if (cfg_wr && (cfg_paddr[2] == REG_FRAME_COUNT)) begin
      frame_count_nxt = cfg_pwdata[COUNT_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt        = state_r;
    scan_idx_nxt     = scan_idx_r;
    lim_nxt          = lim_r;
    op_nxt           = op_r;
    frame_nxt        = frame_r;
    kern_nxt         = kern_r;
    wr_nxt           = wr_r;
    res_frame_nxt    = res_frame_r;
    res_present_nxt  = res_present_r;
    res_writable_nxt = res_writable_r;
    res_user_nxt     = res_user_r;
    res_no_free_nxt  = res_no_free_r;
    res_in_use_nxt   = res_in_use_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_frame_nxt    = out_frame_r;
    out_present_nxt  = out_present_r;
    out_writable_nxt = out_writable_r;
    out_user_nxt     = out_user_r;
    out_no_free_nxt  = out_no_free_r;
    out_in_use_nxt   = out_in_use_r;
    ram_we           = 1'b0;
    ram_waddr        = scan_idx_r[WA_W-1:0];
    ram_wdata        = 32'h0;
    ram_raddr        = in_word_ext[WA_W-1:0];

    unique case (state_r)
      ST_CLR: begin
        ram_we = 1'b1;
        if (scan_idx_r == CNT_W'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end

      ST_IDLE: begin
        // An alloc search starts at word zero; free and test read the frame's word.
        if (in_op == OP_ALLOC) begin
          ram_raddr = '0;
        end
        if (in_valid) begin
          op_nxt           = in_op;
          frame_nxt        = in_frame;
          kern_nxt         = in_kernel;
          wr_nxt           = in_writable;
          lim_nxt          = lim_ext[CNT_W-1:0];
          scan_idx_nxt     = '0;
          res_frame_nxt    = '0;
          res_present_nxt  = 1'b0;
          res_writable_nxt = 1'b0;
          res_user_nxt     = 1'b0;
          res_no_free_nxt  = 1'b0;
          res_in_use_nxt   = 1'b0;
          unique case (in_op)
            OP_ALLOC: begin
              if (in_frame != '0) begin
                res_frame_nxt = in_frame;
                state_nxt     = ST_RESP;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_FREE, OP_TEST: state_nxt = ST_FT;
            default:          state_nxt = ST_RESP;
          endcase
        end
      end

      ST_FT: begin
        // Read data holds the frame's word: clear its bit or report it.
        ram_waddr = WA_W'(32'(frame_r) >> 5);
        ram_wdata = ram_rdata & ~(32'h1 << frame_r[4:0]);
        if (op_r == OP_FREE) begin
          ram_we = (frame_r != '0) && frame_in_range;
        end else begin
          res_in_use_nxt = frame_in_range && ram_rdata[frame_r[4:0]];
        end
        state_nxt = ST_RESP;
      end

      ST_SCAN: begin
        // Read data holds word scan_idx_r; the next word is fetched meanwhile.
        ram_raddr = WA_W'(scan_idx_r + 1'b1);
        ram_wdata = ram_rdata | (32'h1 << ffz_res.pos);
        if (scan_idx_r >= lim_r) begin
          res_no_free_nxt = 1'b1;
          state_nxt       = ST_RESP;
        end else if (ffz_res.found) begin
          ram_we           = 1'b1;
          res_frame_nxt    = found_ext[FRAME_W-1:0];
          res_present_nxt  = 1'b1;
          res_writable_nxt = wr_r;
          res_user_nxt     = ~kern_r;
          state_nxt        = ST_RESP;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_frame_nxt    = res_frame_r;
          out_present_nxt  = res_present_r;
          out_writable_nxt = res_writable_r;
          out_user_nxt     = res_user_r;
          out_no_free_nxt  = res_no_free_r;
          out_in_use_nxt   = res_in_use_r;
          state_nxt        = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      scan_idx_r    <= '0;
      lim_r         <= '0;
      frame_count_r <= FRAME_COUNT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      scan_idx_r    <= scan_idx_nxt;
      lim_r         <= lim_nxt;
      frame_count_r <= frame_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    frame_r        <= frame_nxt;
    kern_r         <= kern_nxt;
    wr_r           <= wr_nxt;
    res_frame_r    <= res_frame_nxt;
    res_present_r  <= res_present_nxt;
    res_writable_r <= res_writable_nxt;
    res_user_r     <= res_user_nxt;
    res_no_free_r  <= res_no_free_nxt;
    res_in_use_r   <= res_in_use_nxt;
    out_frame_r    <= out_frame_nxt;
    out_present_r  <= out_present_nxt;
    out_writable_r <= out_writable_nxt;
    out_user_r     <= out_user_nxt;
    out_no_free_r  <= out_no_free_nxt;
    out_in_use_r   <= out_in_use_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_frame_index = out_frame_r;
  assign out_present     = out_present_r;
  assign out_writable    = out_writable_r;
  assign out_user_access = out_user_r;
  assign out_no_free     = out_no_free_r;
  assign out_in_use      = out_in_use_r;

`ifndef SYNTHESIS
  // The bitmap is never written while the block waits for a word.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("bitmap written while idle");

  // The scan never runs past the search limit.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_idx_r <= lim_r))
    else $error("scan index beyond limit");

  // A full-map result never reports a new allocation.
  a_nofree_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_no_free_r && out_present_r))
    else $error("no_free together with present");

  // An accepted word closes the request side on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request side open right after accept");
`endif

endmodule
